>>> hdl/plob_pkg.sv
// shared types and constants of the price level order book
`default_nettype none

package plob_pkg;

    // fixed field widths
    localparam int QTY_W          = 31;
    localparam int TS_W           = 48;
    localparam int PRICE_W        = 32;

    // default sizes of the book
    localparam int BOOK_DEPTH_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    // stream widths
    localparam int IN_TDATA_W     = 112;
    localparam int IN_TUSER_W     = 2;
    localparam int OUT_TDATA_W    = 176;
    localparam int OUT_TUSER_W    = 1;

    // input codes
    localparam logic OPC_APPLY = 1'b0;
    localparam logic OPC_CLEAR = 1'b1;
    localparam logic SIDE_ASK  = 1'b0;
    localparam logic SIDE_BID  = 1'b1;

    // action applied by every cell of a row in the update cycle
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_INSERT  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_REPLACE = 3'd4
    } cell_op_t;

    // broadcast control for one row of cells
    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
    } cell_ctl_t;

    // control from the sequencer to one side
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic act;
        logic clr;
    } side_ctl_t;

endpackage

`default_nettype wire

>>> hdl/plob_cell.sv
// one price level cell: holds a level, compares it with the key and shifts with its neighbors
`default_nettype none

module plob_cell #(
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter bit DESC       = 1'b0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  plob_pkg::cell_ctl_t        ctl,
    input  wire [PRICE_BITS-1:0]       key_price,
    input  wire [plob_pkg::QTY_W-1:0]  key_qty,
    input  wire [PRICE_BITS-1:0]       prev_price,
    input  wire [plob_pkg::QTY_W-1:0]  prev_qty,
    input  wire                        prev_valid,
    input  wire                        prev_e,
    input  wire [PRICE_BITS-1:0]       succ_price,
    input  wire [plob_pkg::QTY_W-1:0]  succ_qty,
    input  wire                        succ_valid,
    output logic [PRICE_BITS-1:0]      price,
    output logic [plob_pkg::QTY_W-1:0] qty,
    output logic                       valid,
    output logic                       e,
    output logic                       match,
    output logic [PRICE_BITS-1:0]      price_nxt,
    output logic [plob_pkg::QTY_W-1:0] qty_nxt,
    output logic                       valid_nxt
);
    import plob_pkg::*;

    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic                  valid_reg;
    logic                  e_reg;
    logic                  match_reg;
    logic                  match_now;
    logic                  after_now;
    logic                  e_now;

    // compare against the key
    always_comb
    begin
        match_now = valid_reg && (price_reg == key_price);
        after_now = DESC ? (price_reg < key_price) : (price_reg > key_price);
        e_now     = !valid_reg || match_now || after_now;
    end

    // next contents of the cell
    always_comb
    begin
        price_nxt = price_reg;
        qty_nxt   = qty_reg;
        valid_nxt = valid_reg;
        case (ctl.op)
            OP_CLEAR:
            begin
                valid_nxt = 1'b0;
            end
            OP_INSERT:
            begin
                if (e_reg)
                begin
                    if (prev_e)
                    begin
                        price_nxt = prev_price;
                        qty_nxt   = prev_qty;
                        valid_nxt = prev_valid;
                    end
                    else
                    begin
                        price_nxt = key_price;
                        qty_nxt   = key_qty;
                        valid_nxt = 1'b1;
                    end
                end
            end
            OP_DELETE:
            begin
                if (e_reg)
                begin
                    price_nxt = succ_price;
                    qty_nxt   = succ_qty;
                    valid_nxt = succ_valid;
                end
            end
            OP_REPLACE:
            begin
                if (match_reg)
                begin
                    qty_nxt = key_qty;
                end
            end
            default:
            begin
                valid_nxt = valid_reg;
            end
        endcase
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            e_reg     <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_nxt;
            if (ctl.cmp_en)
            begin
                e_reg     <= e_now;
                match_reg <= match_now;
            end
        end
    end

    // level payload
    always_ff @(posedge clk)
    begin
        price_reg <= price_nxt;
        qty_reg   <= qty_nxt;
    end

    assign price = price_reg;
    assign qty   = qty_reg;
    assign valid = valid_reg;
    assign e     = e_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

>>> hdl/plob_side.sv
// one side of the book: a sorted row of level cells and its update decode
`default_nettype none

module plob_side #(
    parameter int BOOK_DEPTH = plob_pkg::BOOK_DEPTH_DEF,
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter bit DESC       = 1'b0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  plob_pkg::side_ctl_t        ctl,
    input  wire [PRICE_BITS-1:0]       key_price,
    input  wire [plob_pkg::QTY_W-1:0]  key_qty,
    output logic                       head_valid,
    output logic [PRICE_BITS-1:0]      head_price,
    output logic [plob_pkg::QTY_W-1:0] head_qty,
    output logic                       ovf
);
    import plob_pkg::*;

    logic [PRICE_BITS-1:0] price_a   [BOOK_DEPTH];
    logic [QTY_W-1:0]      qty_a     [BOOK_DEPTH];
    logic [PRICE_BITS-1:0] prev_pa   [BOOK_DEPTH];
    logic [QTY_W-1:0]      prev_qa   [BOOK_DEPTH];
    logic [PRICE_BITS-1:0] succ_pa   [BOOK_DEPTH];
    logic [QTY_W-1:0]      succ_qa   [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] valid_vec;
    logic [BOOK_DEPTH-1:0] e_vec;
    logic [BOOK_DEPTH-1:0] match_vec;
    logic [BOOK_DEPTH-1:0] prev_vv;
    logic [BOOK_DEPTH-1:0] prev_ev;
    logic [BOOK_DEPTH-1:0] succ_vv;
    logic                  any_match;
    logic                  qty_zero;
    cell_ctl_t             cell_ctl;

    assign any_match = |match_vec;
    assign qty_zero  = (key_qty == '0);

    // decode the row action
    always_comb
    begin
        cell_ctl.cmp_en = ctl.cmp_en;
        cell_ctl.op     = OP_HOLD;
        if (ctl.upd_en)
        begin
            if (ctl.clr)
            begin
                cell_ctl.op = OP_CLEAR;
            end
            else if (ctl.act)
            begin
                if (any_match)
                begin
                    cell_ctl.op = qty_zero ? OP_DELETE : OP_REPLACE;
                end
                else if (!qty_zero)
                begin
                    cell_ctl.op = OP_INSERT;
                end
            end
        end
    end

    // a new level at a full side drops the worst one
    assign ovf = ctl.act && !any_match && !qty_zero && valid_vec[BOOK_DEPTH-1];

    // row of cells with neighbor links
    for (genvar i = 0; i < BOOK_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign prev_pa[i] = '0;
            assign prev_qa[i] = '0;
            assign prev_vv[i] = 1'b0;
            assign prev_ev[i] = 1'b0;
        end
        else
        begin : g_mid
            assign prev_pa[i] = price_a[i-1];
            assign prev_qa[i] = qty_a[i-1];
            assign prev_vv[i] = valid_vec[i-1];
            assign prev_ev[i] = e_vec[i-1];
        end

        if (i == BOOK_DEPTH - 1)
        begin : g_last
            assign succ_pa[i] = '0;
            assign succ_qa[i] = '0;
            assign succ_vv[i] = 1'b0;
        end
        else
        begin : g_inner
            assign succ_pa[i] = price_a[i+1];
            assign succ_qa[i] = qty_a[i+1];
            assign succ_vv[i] = valid_vec[i+1];
        end

        if (i == 0)
        begin : g_head
            plob_cell #(
                .PRICE_BITS (PRICE_BITS),
                .DESC       (DESC)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .key_price  (key_price),
                .key_qty    (key_qty),
                .prev_price (prev_pa[i]),
                .prev_qty   (prev_qa[i]),
                .prev_valid (prev_vv[i]),
                .prev_e     (prev_ev[i]),
                .succ_price (succ_pa[i]),
                .succ_qty   (succ_qa[i]),
                .succ_valid (succ_vv[i]),
                .price      (price_a[i]),
                .qty        (qty_a[i]),
                .valid      (valid_vec[i]),
                .e          (e_vec[i]),
                .match      (match_vec[i]),
                .price_nxt  (head_price),
                .qty_nxt    (head_qty),
                .valid_nxt  (head_valid)
            );
        end
        else
        begin : g_body
            plob_cell #(
                .PRICE_BITS (PRICE_BITS),
                .DESC       (DESC)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .key_price  (key_price),
                .key_qty    (key_qty),
                .prev_price (prev_pa[i]),
                .prev_qty   (prev_qa[i]),
                .prev_valid (prev_vv[i]),
                .prev_e     (prev_ev[i]),
                .succ_price (succ_pa[i]),
                .succ_qty   (succ_qa[i]),
                .succ_valid (succ_vv[i]),
                .price      (price_a[i]),
                .qty        (qty_a[i]),
                .valid      (valid_vec[i]),
                .e          (e_vec[i]),
                .match      (match_vec[i]),
                .price_nxt  (),
                .qty_nxt    (),
                .valid_nxt  ()
            );
        end
    end

    // occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + BOOK_DEPTH'(1))) == '0)
        else $error("occupied cells are not a prefix");

    // prices are distinct, so at most one cell matches
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // a clear empties the row
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.upd_en && ctl.clr) |=> (valid_vec == '0))
        else $error("row not empty after clear");

endmodule

`default_nettype wire

>>> hdl/price_level_order_book.sv
// top level of the price level order book: sequencer, item register and result register
// each transaction passes a compare state and a shift (update) state through the rows of
//   level cells, and its result is then registered; the update waits while an earlier
//   result is still held, and the next transaction is accepted as the update finishes
// reset: both sides empty, no result pending, ready to accept
// the result register lets a new transaction in while the last result waits
`default_nettype none

module price_level_order_book #(
    parameter int BOOK_DEPTH = plob_pkg::BOOK_DEPTH_DEF,
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // price[31:0], quantity[62:32], timestamp[110:63], zero pad[111]
    input  wire [plob_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // opcode[0], side[1]
    input  wire [plob_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // bid_present[0], best_bid_price[32:1], best_bid_quantity[63:33],
    // ask_present[64], best_ask_price[96:65], best_ask_quantity[127:97],
    // book_time[175:128]
    output logic [plob_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // overflow[0]
    output logic [plob_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import plob_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  opcode_reg;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic [TS_W-1:0]       ts_reg;
    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                  accept;
    logic                  done;
    side_ctl_t             ask_ctl;
    side_ctl_t             bid_ctl;
    logic                  ask_valid;
    logic [PRICE_BITS-1:0] ask_price;
    logic [QTY_W-1:0]      ask_qty;
    logic                  ask_ovf;
    logic                  bid_valid;
    logic [PRICE_BITS-1:0] bid_price;
    logic [QTY_W-1:0]      bid_qty;
    logic                  bid_ovf;
    logic [PRICE_W-1:0]    bid_p_out;
    logic [QTY_W-1:0]      bid_q_out;
    logic [PRICE_W-1:0]    ask_p_out;
    logic [QTY_W-1:0]      ask_q_out;

    // handshake
    assign done          = (state_reg == ST_UPD) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) || done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (done)
                begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= s_axis_tuser[0];
            side_reg   <= s_axis_tuser[1];
            price_reg  <= PRICE_BITS'(s_axis_tdata[31:0]);
            qty_reg    <= s_axis_tdata[62:32];
            ts_reg     <= s_axis_tdata[110:63];
        end
    end

    // side control
    always_comb
    begin
        ask_ctl.cmp_en = (state_reg == ST_CMP);
        ask_ctl.upd_en = done;
        ask_ctl.clr    = (opcode_reg == OPC_CLEAR);
        ask_ctl.act    = (opcode_reg == OPC_APPLY) && (side_reg == SIDE_ASK);
        bid_ctl.cmp_en = (state_reg == ST_CMP);
        bid_ctl.upd_en = done;
        bid_ctl.clr    = (opcode_reg == OPC_CLEAR);
        bid_ctl.act    = (opcode_reg == OPC_APPLY) && (side_reg == SIDE_BID);
    end

    plob_side #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .DESC       (1'b0)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ask_ctl),
        .key_price  (price_reg),
        .key_qty    (qty_reg),
        .head_valid (ask_valid),
        .head_price (ask_price),
        .head_qty   (ask_qty),
        .ovf        (ask_ovf)
    );

    plob_side #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .DESC       (1'b1)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bid_ctl),
        .key_price  (price_reg),
        .key_qty    (qty_reg),
        .head_valid (bid_valid),
        .head_price (bid_price),
        .head_qty   (bid_qty),
        .ovf        (bid_ovf)
    );

    // best levels, zero when a side is empty
    assign bid_p_out = bid_valid ? PRICE_W'(bid_price) : '0;
    assign bid_q_out = bid_valid ? bid_qty : '0;
    assign ask_p_out = ask_valid ? PRICE_W'(ask_price) : '0;
    assign ask_q_out = ask_valid ? ask_qty : '0;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= {ts_reg, ask_q_out, ask_p_out, ask_valid,
                             bid_q_out, bid_p_out, bid_valid};
            out_user_reg <= OUT_TUSER_W'(ask_ovf | bid_ovf);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // an accepted transaction starts its compare cycle
    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CMP))
        else $error("accepted transaction did not start compare");

    // compare is always followed by update
    a_cmp_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (state_reg == ST_UPD))
        else $error("compare not followed by update");

    // a finished update presents its result
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_axis_tvalid)
        else $error("result missing after update");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench of the price level order book, with its own book predictor
`timescale 1ns / 1ps

module tb_top;

    import plob_pkg::*;

    localparam int DEPTH      = BOOK_DEPTH_DEF;
    localparam int ITEM_GOAL  = 1750;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 8;

    // one level update or clear as it travels on the input stream
    typedef struct packed {
        logic               opcode;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [TS_W-1:0]    ts;
    } level_item_t;

    // best levels of both sides plus time and overflow
    typedef struct packed {
        logic               bid_present;
        logic [PRICE_W-1:0] bid_price;
        logic [QTY_W-1:0]   bid_qty;
        logic               ask_present;
        logic [PRICE_W-1:0] ask_price;
        logic [QTY_W-1:0]   ask_qty;
        logic [TS_W-1:0]    book_time;
        logic               overflow;
    } book_top_t;

    // item with an optional hand-written expectation
    typedef struct packed {
        level_item_t item;
        logic        has_top;
        book_top_t   top;
    } book_msg_t;

    // row of the directed table, repeated reps times with a price step
    typedef struct {
        logic               opcode;
        logic               side;
        logic [PRICE_W-1:0] price;
        int                 step;
        int                 reps;
        logic [QTY_W-1:0]   qty;
        logic [TS_W-1:0]    ts;
        logic               has_top;
        book_top_t          top;
    } table_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // predictor state: index 0 holds asks ascending, index 1 bids descending
    logic [PRICE_W-1:0] lvl_price [2][DEPTH];
    logic [QTY_W-1:0]   lvl_qty   [2][DEPTH];
    int                 lvl_count [2];
    logic [TS_W-1:0]    held_time;

    book_top_t  expected_tops[$];
    book_msg_t  drv_msg;
    table_row_t dir_rows[$];
    int         err_count;
    int         idle_cycles;
    bit         src_idle;
    bit         snk_idle;
    bit         hold_req;

    price_level_order_book i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // apply one level to one side, returns 1 when a level was dropped
    function automatic logic update_side(logic sd, logic [PRICE_W-1:0] p,
                                         logic [QTY_W-1:0] q);
        int   n;
        int   pos;
        int   keep;
        int   i;
        logic found;
        n     = lvl_count[sd];
        pos   = n;
        found = 1'b0;
        // first entry that holds the price or sorts after it
        for (i = 0; i < n; i++)
        begin
            if (!found && (lvl_price[sd][i] == p ||
                (sd == SIDE_BID ? lvl_price[sd][i] < p : lvl_price[sd][i] > p)))
            begin
                pos   = i;
                found = 1'b1;
            end
        end
        // price already held: delete or replace
        if (pos < n && lvl_price[sd][pos] == p)
        begin
            if (q == '0)
            begin
                for (i = pos; i < n - 1; i++)
                begin
                    lvl_price[sd][i] = lvl_price[sd][i + 1];
                    lvl_qty[sd][i]   = lvl_qty[sd][i + 1];
                end
                lvl_count[sd] = n - 1;
            end
            else
            begin
                lvl_qty[sd][pos] = q;
            end
            return 1'b0;
        end
        // delete of an absent price
        if (q == '0)
            return 1'b0;
        // full side: the worst level goes, possibly the new one
        if (n >= DEPTH)
        begin
            if (pos >= DEPTH)
                return 1'b1;
            keep = DEPTH - 1;
        end
        else
        begin
            keep = n;
        end
        for (i = keep; i > pos; i--)
        begin
            lvl_price[sd][i] = lvl_price[sd][i - 1];
            lvl_qty[sd][i]   = lvl_qty[sd][i - 1];
        end
        lvl_price[sd][pos] = p;
        lvl_qty[sd][pos]   = q;
        lvl_count[sd]      = keep + 1;
        return (n >= DEPTH);
    endfunction

    // next book state and its best levels for one accepted transaction
    function automatic book_top_t apply_update(level_item_t it);
        book_top_t t;
        t         = '0;
        held_time = it.ts;
        if (it.opcode == OPC_CLEAR)
        begin
            lvl_count[SIDE_ASK] = 0;
            lvl_count[SIDE_BID] = 0;
        end
        else
        begin
            t.overflow = update_side(it.side, it.price, it.qty);
        end
        if (lvl_count[SIDE_BID] > 0)
        begin
            t.bid_present = 1'b1;
            t.bid_price   = lvl_price[SIDE_BID][0];
            t.bid_qty     = lvl_qty[SIDE_BID][0];
        end
        if (lvl_count[SIDE_ASK] > 0)
        begin
            t.ask_present = 1'b1;
            t.ask_price   = lvl_price[SIDE_ASK][0];
            t.ask_qty     = lvl_qty[SIDE_ASK][0];
        end
        t.book_time = held_time;
        return t;
    endfunction

    function automatic book_msg_t mk_msg(logic op, logic sd, logic [PRICE_W-1:0] p,
                                         logic [QTY_W-1:0] q, logic [TS_W-1:0] t);
        book_msg_t m;
        m             = '0;
        m.item.opcode = op;
        m.item.side   = sd;
        m.item.price  = p;
        m.item.qty    = q;
        m.item.ts     = t;
        return m;
    endfunction

    function automatic book_top_t mk_top(logic bp, logic [PRICE_W-1:0] bpr,
                                         logic [QTY_W-1:0] bq, logic ap,
                                         logic [PRICE_W-1:0] apr, logic [QTY_W-1:0] aq,
                                         logic [TS_W-1:0] t, logic ov);
        book_top_t r;
        r.bid_present = bp;
        r.bid_price   = bpr;
        r.bid_qty     = bq;
        r.ask_present = ap;
        r.ask_price   = apr;
        r.ask_qty     = aq;
        r.book_time   = t;
        r.overflow    = ov;
        return r;
    endfunction

    function automatic table_row_t mk_row(logic op, logic sd, logic [PRICE_W-1:0] p,
                                          int step, int reps, logic [QTY_W-1:0] q,
                                          logic [TS_W-1:0] t, logic has_top,
                                          book_top_t top);
        table_row_t r;
        r.opcode  = op;
        r.side    = sd;
        r.price   = p;
        r.step    = step;
        r.reps    = reps;
        r.qty     = q;
        r.ts      = t;
        r.has_top = has_top;
        r.top     = top;
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one transaction from a falling edge and wait until it is taken
    task automatic send_item(book_msg_t m);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        drv_msg = m;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, m.item.ts, m.item.qty, m.item.price};
        s_axis_tuser  <= {m.item.side, m.item.opcode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            err_count++;
        end
    endtask

    // prediction on accepted input, comparison on accepted output
    always @(posedge clk)
    begin
        book_top_t want;
        book_top_t got;
        book_top_t pred;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pred = apply_update(drv_msg.item);
            expected_tops.push_back(drv_msg.has_top ? drv_msg.top : pred);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.bid_present = m_axis_tdata[0];
            got.bid_price   = m_axis_tdata[32:1];
            got.bid_qty     = m_axis_tdata[63:33];
            got.ask_present = m_axis_tdata[64];
            got.ask_price   = m_axis_tdata[96:65];
            got.ask_qty     = m_axis_tdata[127:97];
            got.book_time   = m_axis_tdata[175:128];
            got.overflow    = m_axis_tuser[0];
            if (expected_tops.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $realtime, got);
                err_count++;
            end
            else
            begin
                want = expected_tops.pop_front();
                report_field("bid_present", want.bid_present, got.bid_present);
                report_field("best_bid_price", want.bid_price, got.bid_price);
                report_field("best_bid_quantity", want.bid_qty, got.bid_qty);
                report_field("ask_present", want.ask_present, got.ask_present);
                report_field("best_ask_price", want.ask_price, got.ask_price);
                report_field("best_ask_quantity", want.ask_qty, got.ask_qty);
                report_field("book_time", want.book_time, got.book_time);
                report_field("overflow", want.overflow, got.overflow);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial
    begin
        int gap;
        int hold_cnt;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_LEN)
                begin
                    @(negedge clk);
                    hold_cnt++;
                end
            end
            else
            begin
                gap = snk_idle ? pick_gap() : 0;
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // main sequence: reset, directed table, random snapshots, drain
    initial
    begin
        table_row_t         row;
        book_msg_t          msg;
        logic [PRICE_W-1:0] base;
        logic [PRICE_W-1:0] p;
        logic [QTY_W-1:0]   q;
        logic [TS_W-1:0]    ts;
        int                 sent;
        int                 span;
        int                 count;
        int                 i;
        int                 k;
        int                 r;
        bit                 one_side;
        bit                 fixed_side;
        bit                 held;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        drv_msg       = '0;
        err_count     = 0;
        idle_cycles   = 0;
        src_idle      = 1'b0;
        snk_idle      = 1'b0;
        hold_req      = 1'b0;
        lvl_count[0]  = 0;
        lvl_count[1]  = 0;
        held_time     = '0;

        // directed table
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd100, 0, 1, '0, '0, 1'b1,
                                  mk_top(0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(mk_row(OPC_CLEAR, SIDE_BID, '1, 0, 1, '1, '1, 1'b1,
                                  mk_top(0, 0, 0, 0, 0, 0, '1, 0)));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, '0, 0, 1, '1, 48'd1, 1'b1,
                                  mk_top(0, 0, 0, 1, 0, '1, 48'd1, 0)));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, '1, 0, 1, 31'd1, 48'd2, 1'b1,
                                  mk_top(1, '1, 31'd1, 1, 0, '1, 48'd2, 0)));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, 32'd500, 0, 1, 31'd7, 48'd3, 1'b0, '0));
        // replace the best bid
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, '1, 0, 1, 31'd9, 48'd4, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd10, 0, 1, 31'd5, 48'd5, 1'b0, '0));
        // delete the best ask, then an absent bid, then the best bid
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, '0, 0, 1, '0, 48'd6, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, 32'd1234, 0, 1, '0, 48'd7, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, '1, 0, 1, '0, 48'd8, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_CLEAR, SIDE_ASK, '0, 0, 1, '0, 48'd9, 1'b1,
                                  mk_top(0, 0, 0, 0, 0, 0, 48'd9, 0)));
        // fill the ask side, then overflow with a better and with a worst level
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd1000, 1, DEPTH, 31'd1, 48'd100,
                                  1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd999, 0, 1, 31'd3, 48'd200, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd5000, 0, 1, 31'd4, 48'd201, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_ASK, 32'd1000, 0, 1, '0, 48'd202, 1'b0, '0));
        // same for the bid side, filled from the top down
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, 32'd2000, -1, DEPTH, 31'd2, 48'd300,
                                  1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, 32'd3000, 0, 1, 31'd6, 48'd400, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, '0, 0, 1, 31'd8, 48'd401, 1'b0, '0));
        dir_rows.push_back(mk_row(OPC_APPLY, SIDE_BID, 32'd1990, 0, 1, 31'd11, 48'd402,
                                  1'b0, '0));
        dir_rows.push_back(mk_row(OPC_CLEAR, SIDE_BID, 32'h8000_0001, 0, 1, 31'h5555_5555,
                                  48'h8000_0000_0001, 1'b1,
                                  mk_top(0, 0, 0, 0, 0, 0, 48'h8000_0000_0001, 0)));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sent = 0;
        foreach (dir_rows[j])
        begin
            row = dir_rows[j];
            for (k = 0; k < row.reps; k++)
            begin
                p   = row.price + row.step * k;
                msg = mk_msg(row.opcode, row.side, p, row.qty, row.ts + k);
                msg.has_top = row.has_top;
                msg.top     = row.top;
                send_item(msg);
                sent++;
            end
        end

        // random part: mostly snapshots with updates, some noise
        ts   = 48'd1000;
        held = 1'b0;
        while (sent < ITEM_GOAL)
        begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            if (!held && sent > ITEM_GOAL / 2)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
                src_idle = 1'b0;
            end
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                // snapshot: clear with random fields, then level updates
                ts = ts + $urandom_range(1, 50);
                send_item(mk_msg(OPC_CLEAR, 1'($urandom), PRICE_W'($urandom),
                                 QTY_W'($urandom), ts));
                sent++;
                base = $urandom;
                case ($urandom_range(0, 3))
                    0: span = 8;
                    1: span = 40;
                    2: span = 90;
                    default: span = 200;
                endcase
                count      = $urandom_range(10, 130);
                one_side   = ($urandom_range(0, 2) == 0);
                fixed_side = 1'($urandom);
                for (i = 0; i < count; i++)
                begin
                    p = base + $urandom_range(0, span);
                    case ($urandom_range(0, 5))
                        0: q = '0;
                        1: q = QTY_W'($urandom);
                        default: q = QTY_W'($urandom_range(1, 1000));
                    endcase
                    if ($urandom_range(0, 15) == 0)
                        ts = TS_W'({$urandom, $urandom});
                    else
                        ts = ts + $urandom_range(0, 3);
                    send_item(mk_msg(OPC_APPLY, one_side ? fixed_side : 1'($urandom), p, q,
                                     ts));
                    sent++;
                end
            end
            else
            begin
                // noise: fully random fields
                count = $urandom_range(1, 8);
                for (i = 0; i < count; i++)
                begin
                    send_item(mk_msg($urandom_range(0, 3) == 0, 1'($urandom),
                                     PRICE_W'($urandom), QTY_W'($urandom),
                                     TS_W'({$urandom, $urandom})));
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        snk_idle = 1'b0;

        // drain
        while (expected_tops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
hdl/plob_pkg.sv
hdl/plob_cell.sv
hdl/plob_side.sv
hdl/price_level_order_book.sv
test/tb_top.sv
